[design/chunk_pool_allocator_top_defines.svh]
// ---------------------------------------------------------------------------
// Chunk pool allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef CHUNK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define CHUNK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define CPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cpa_pkg.sv]
// ---------------------------------------------------------------------------
// Chunk pool allocator package
// Payload types, status codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package cpa_pkg;

  localparam int unsigned CHUNKS_DEF = 256;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned REQ_W      = 24;
  localparam int unsigned NUM_W      = 25;  // numerator of the chunk-count division
  localparam int unsigned BYTES_W    = 25;
  localparam int unsigned HEAD_W     = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [CFG_W-1:0]  CHUNK_BYTES_RST = 17'd128;
  localparam logic [ADDR_W-1:0] REG_CHUNK_BYTES = 3'd0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RUN  = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_NOT_ALC = 2'd3;

  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [REQ_W-1:0]  request_bytes;
    logic [HEAD_W-1:0] block_index;
  } cpa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [HEAD_W-1:0]  head_index;
    logic [BYTES_W-1:0] granted_bytes;
    logic [CNT_W-1:0]   used_chunks;
    logic [CNT_W-1:0]   live_blocks;
  } cpa_out_t;

  typedef enum logic [1:0] {
    SEL_CLR,
    SEL_P,
    SEL_Q,
    SEL_IDX
  } ram_sel_e;

  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       div_step;
    logic       load_p;
    logic       set_q;
    logic       inc_q;
    logic       adv;
    logic       adv_one;
    logic       we;
    ram_sel_e   sel;
    logic       wr_need;
    logic       grant;
    logic       free_upd;
    logic       emit;
    logic [1:0] status;
  } cpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic mode;
    logic req_zero;
    logic idx_ok;
    logic too_big;
    logic rd_zero;
    logic fits;
    logic need_one;
    logic q_last;
    logic iter_last;
  } cpa_sts_t;

endpackage

[design/chunk_pool_allocator_top.sv]
// ---------------------------------------------------------------------------
// Chunk pool allocator
// Next-fit allocator over a fixed pool of equal chunks, command interface.
// ---------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; each one
// yields exactly one result beat on rsp_o, marked by done_o for a single
// cycle, and the receiver cannot stall it, so capture it when done_o is high.
// After reset the block sweeps its run-length RAM to zero with busy high.
// A zero-size request or a free of an invalid index is answered from the
// decode state; any other free goes on to a check of its head. An allocate
// runs a restoring divider to turn bytes into chunks, then walks the pool
// from the cursor, reading each candidate head and then each further chunk
// of the run, all through the single RAM port. Configure chunk_bytes only
// while busy is low and no result is pending.
// ---------------------------------------------------------------------------
module chunk_pool_allocator_top
  import cpa_pkg::*;
#(
  parameter int unsigned CHUNKS = CHUNKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request beat
  input  logic              start,
  output logic              busy,
  input  cpa_in_t           req_i,
  // result beat
  output logic              done_o,
  output cpa_out_t          rsp_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "chunk_pool_allocator_top_defines.svh"

  logic [CFG_W-1:0] chunk_bytes_q;
  cpa_cmd_t         cmd;
  cpa_sts_t         sts;

  // Write chunk_bytes on the access phase; other addresses drop the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bytes_q <= CHUNK_BYTES_RST;
    end else if (psel && penable && pwrite && paddr == REG_CHUNK_BYTES) begin
      chunk_bytes_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr == REG_CHUNK_BYTES) ? 32'(chunk_bytes_q) : '0;
  assign pready = 1'b1;

  cpa_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy_o(busy)
  );

  cpa_datapath #(.CHUNKS(CHUNKS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .chunk_bytes_i(chunk_bytes_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

  // An accepted beat always leaves the idle state.
  `CPA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
  // Results never come on back-to-back cycles.
  `CPA_ASSERT_NEXT(a_done_gap, done_o, !done_o, "result strobe held two cycles")
  // A failed request reports no block and no bytes.
  `CPA_ASSERT_SAME(a_fail_zero, done_o && rsp_o.status != ST_OK,
                   rsp_o.head_index == '0 && rsp_o.granted_bytes == '0,
                   "failed result carries a block")

endmodule

[design/cpa_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module cpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cpa_datapath.sv]
// ---------------------------------------------------------------------------
// Chunk pool allocator datapath
// Run-length RAM, search pointers, counters, chunk-count divider, result.
// ---------------------------------------------------------------------------
module cpa_datapath
  import cpa_pkg::*;
#(
  parameter int unsigned CHUNKS = CHUNKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpa_in_t          req_i,
  input  logic [CFG_W-1:0] chunk_bytes_i,
  input  cpa_cmd_t         cmd_i,
  output cpa_sts_t         sts_o,
  output logic             done_o,
  output cpa_out_t         rsp_o
);

  localparam int unsigned IW = $clog2(CHUNKS);
  localparam int unsigned CW = $clog2(CHUNKS + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned DW = $clog2(NUM_W);

  logic [CFG_W-1:0] cb;
  assign cb = (chunk_bytes_i == '0) ? CFG_W'(1) : chunk_bytes_i;

  // latched request
  logic          mode_q, req_zero_q, idx_ok_q;
  logic [IW-1:0] idx_q;

  // divider: n_q shifts out numerator bits and in quotient bits
  logic [NUM_W-1:0] n_q, n_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [DW-1:0]    dcnt_q, dcnt_d;
  logic [CFG_W:0]   rem_sh;
  logic             ge;

  logic [IW-1:0] p_q, p_d, q_q, q_d, i_q, i_d, clr_q, clr_d, cur_q, cur_d;
  logic [CW-1:0] need_q, need_d, used_q, used_d, blk_q, blk_d;
  logic [CW-1:0] rd, skip;
  logic [PW-1:0] psum;

  logic [IW-1:0] ram_addr;
  logic [CW-1:0] ram_wdata;

  logic [CW+CFG_W-1:0] prod;
  logic [CW-1:0]       mop;

  logic     done_q;
  cpa_out_t rsp_q, rsp_d;

  cpa_ram #(.WIDTH(CW), .DEPTH(CHUNKS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rd)
  );

  always_comb begin
    unique case (cmd_i.sel)
      SEL_CLR: ram_addr = clr_q;
      SEL_P:   ram_addr = p_q;
      SEL_Q:   ram_addr = q_q;
      SEL_IDX: ram_addr = idx_q;
      default: ram_addr = p_q;
    endcase
  end
  assign ram_wdata = cmd_i.wr_need ? need_q : '0;

  assign rem_sh = {rem_q, n_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, cb};
  assign skip   = (cmd_i.adv_one || rd == '0) ? CW'(1) : rd;
  assign psum   = PW'(p_q) + PW'(skip);
  assign mop    = cmd_i.grant ? need_q : rd;
  assign prod   = (CW+CFG_W)'(mop) * (CW+CFG_W)'(cb);

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    p_d    = p_q;
    q_d    = q_q;
    i_d    = i_q;
    clr_d  = clr_q;
    cur_d  = cur_q;
    need_d = need_q;
    used_d = used_q;
    blk_d  = blk_q;
    if (cmd_i.load) begin
      n_d    = NUM_W'(req_i.request_bytes) + NUM_W'(cb) - NUM_W'(1);
      rem_d  = '0;
      dcnt_d = '0;
    end
    if (cmd_i.div_step) begin
      n_d    = {n_q[NUM_W-2:0], ge};
      rem_d  = ge ? CFG_W'(rem_sh - {1'b0, cb}) : CFG_W'(rem_sh);
      dcnt_d = dcnt_q + DW'(1);
    end
    if (cmd_i.clr_step) begin
      clr_d = clr_q + IW'(1);
    end
    if (cmd_i.load_p) begin
      p_d    = cur_q;
      i_d    = '0;
      need_d = CW'(n_q);
    end
    if (cmd_i.set_q) begin
      q_d = p_q + IW'(1);
    end
    if (cmd_i.inc_q) begin
      q_d = q_q + IW'(1);
    end
    if (cmd_i.adv) begin
      p_d = (psum >= PW'(CHUNKS)) ? '0 : IW'(psum);
      i_d = i_q + IW'(1);
    end
    if (cmd_i.grant) begin
      cur_d  = p_q;
      used_d = used_q + need_q;
      blk_d  = blk_q + CW'(1);
    end
    if (cmd_i.free_upd) begin
      used_d = (used_q >= rd) ? used_q - rd : '0;
      blk_d  = (blk_q != '0) ? blk_q - CW'(1) : '0;
    end
  end

  always_comb begin
    rsp_d             = '0;
    rsp_d.status      = cmd_i.status;
    rsp_d.used_chunks = CNT_W'(used_d);
    rsp_d.live_blocks = CNT_W'(blk_d);
    if (cmd_i.grant || cmd_i.free_upd) begin
      rsp_d.head_index    = cmd_i.grant ? HEAD_W'(p_q) : HEAD_W'(idx_q);
      rsp_d.granted_bytes = BYTES_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      cur_q  <= '0;
      used_q <= '0;
      blk_q  <= '0;
      done_q <= 1'b0;
    end else begin
      clr_q  <= clr_d;
      cur_q  <= cur_d;
      used_q <= used_d;
      blk_q  <= blk_d;
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= req_i.mode;
      req_zero_q <= req_i.request_bytes == '0;
      idx_ok_q   <= 32'(req_i.block_index) < CHUNKS;
      idx_q      <= IW'(req_i.block_index);
    end
    n_q    <= n_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    p_q    <= p_d;
    q_q    <= q_d;
    i_q    <= i_d;
    need_q <= need_d;
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.clr_last  = clr_q == IW'(CHUNKS - 1);
  assign sts_o.div_last  = dcnt_q == DW'(NUM_W - 1);
  assign sts_o.mode      = mode_q;
  assign sts_o.req_zero  = req_zero_q;
  assign sts_o.idx_ok    = idx_ok_q;
  assign sts_o.too_big   = 32'(n_q) > CHUNKS;
  assign sts_o.rd_zero   = rd == '0;
  assign sts_o.fits      = PW'(p_q) + PW'(need_q) <= PW'(CHUNKS);
  assign sts_o.need_one  = need_q == CW'(1);
  assign sts_o.q_last    = PW'(q_q) + PW'(1) == PW'(p_q) + PW'(need_q);
  assign sts_o.iter_last = i_q == IW'(CHUNKS - 1);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[design/cpa_ctrl.sv]
// ---------------------------------------------------------------------------
// Chunk pool allocator controller
// Sequences clearing, division, next-fit search, grant and free.
// ---------------------------------------------------------------------------
module cpa_ctrl
  import cpa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cpa_sts_t sts_i,
  output cpa_cmd_t cmd_o,
  output logic     busy_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_NEED  = 4'd4;
  localparam logic [3:0] S_RDP   = 4'd5;
  localparam logic [3:0] S_CHKP  = 4'd6;
  localparam logic [3:0] S_RDQ   = 4'd7;
  localparam logic [3:0] S_CHKQ  = 4'd8;
  localparam logic [3:0] S_GRANT = 4'd9;
  localparam logic [3:0] S_FCHK  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_P;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sel      = SEL_CLR;
        cmd_o.we       = 1'b1;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.sel = SEL_IDX;
        if (sts_i.mode == MODE_FREE) begin
          if (sts_i.idx_ok) begin
            state_d = S_FCHK;
          end else begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NOT_ALC;
            state_d      = S_IDLE;
          end
        end else if (sts_i.req_zero) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_ZERO;
          state_d      = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_NEED;
      end
      S_NEED: begin
        if (sts_i.too_big) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_NO_RUN;
          state_d      = S_IDLE;
        end else begin
          cmd_o.load_p = 1'b1;
          state_d      = S_RDP;
        end
      end
      S_RDP: begin
        state_d = S_CHKP;
      end
      S_CHKP: begin
        if (sts_i.rd_zero && sts_i.fits) begin
          if (sts_i.need_one) begin
            state_d = S_GRANT;
          end else begin
            cmd_o.set_q = 1'b1;
            state_d     = S_RDQ;
          end
        end else if (sts_i.iter_last) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_NO_RUN;
          state_d      = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RDP;
        end
      end
      S_RDQ: begin
        cmd_o.sel = SEL_Q;
        state_d   = S_CHKQ;
      end
      S_CHKQ: begin
        if (!sts_i.rd_zero) begin
          if (sts_i.iter_last) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NO_RUN;
            state_d      = S_IDLE;
          end else begin
            cmd_o.adv     = 1'b1;
            cmd_o.adv_one = 1'b1;
            state_d       = S_RDP;
          end
        end else if (sts_i.q_last) begin
          state_d = S_GRANT;
        end else begin
          cmd_o.inc_q = 1'b1;
          state_d     = S_RDQ;
        end
      end
      S_GRANT: begin
        cmd_o.we      = 1'b1;
        cmd_o.wr_need = 1'b1;
        cmd_o.grant   = 1'b1;
        cmd_o.emit    = 1'b1;
        cmd_o.status  = ST_OK;
        state_d       = S_IDLE;
      end
      S_FCHK: begin
        cmd_o.sel  = SEL_IDX;
        cmd_o.emit = 1'b1;
        if (sts_i.rd_zero) begin
          cmd_o.status = ST_NOT_ALC;
        end else begin
          cmd_o.we       = 1'b1;
          cmd_o.free_upd = 1'b1;
          cmd_o.status   = ST_OK;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

[sim/chunk_pool_allocator_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Chunk pool allocator testbench
// Drives allocate and free beats with random gaps under several chunk sizes,
// predicts each result from a local copy of the pool and checks every field.
// ---------------------------------------------------------------------------
module chunk_pool_allocator_top_tb;
  import cpa_pkg::*;

  localparam int unsigned POOL = CHUNKS_DEF;
  localparam logic MODE_ALLOC = ~MODE_FREE;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cpa_in_t           req_i = '0;
  logic              done_o;
  cpa_out_t          rsp_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Local copy of the pool: run length at each head, cursor and counters.
  int unsigned run_len[POOL];
  int unsigned cursor_q;
  int unsigned used_q;
  int unsigned blocks_q;
  int unsigned chunk_size_q;

  cpa_out_t pending_rsp[$];
  int       fail_count = 0;

  chunk_pool_allocator_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Advance the local pool by one request and return the result it yields.
  function automatic cpa_out_t pool_outcome(cpa_in_t it);
    cpa_out_t    r;
    longint      cb;
    int unsigned need;
    int unsigned p;
    int unsigned skip;
    bit          ok;
    bit          found;
    r = '0;
    cb = (chunk_size_q == 0) ? 1 : chunk_size_q;
    found = 1'b0;
    if (it.mode == MODE_ALLOC) begin
      if (it.request_bytes == 0) begin
        r.status = ST_ZERO;
      end else begin
        need = 32'((longint'(it.request_bytes) + cb - 1) / cb);
        r.status = ST_NO_RUN;
        if (need <= POOL) begin
          p = (cursor_q >= POOL) ? 0 : cursor_q;
          for (int i = 0; i < POOL && !found; i++) begin
            ok = (run_len[p] == 0) && (POOL - p >= need);
            for (int q = p; ok && q < p + need; q++)
              if (run_len[q] != 0) ok = 1'b0;
            if (ok) begin
              found = 1'b1;
              run_len[p] = need;
              cursor_q = p;
              used_q += need;
              blocks_q += 1;
              r.status = ST_OK;
              r.head_index = p[HEAD_W-1:0];
              r.granted_bytes = BYTES_W'(need * cb);
            end else begin
              skip = (run_len[p] == 0) ? 1 : run_len[p];
              p += skip;
              if (p >= POOL) p = 0;
            end
          end
        end
      end
    end else if (run_len[it.block_index] == 0) begin
      r.status = ST_NOT_ALC;
    end else begin
      need = run_len[it.block_index];
      run_len[it.block_index] = 0;
      used_q = (used_q >= need) ? used_q - need : 0;
      blocks_q = (blocks_q > 0) ? blocks_q - 1 : 0;
      r.status = ST_OK;
      r.head_index = it.block_index;
      r.granted_bytes = BYTES_W'(need * cb);
    end
    r.used_chunks = CNT_W'(used_q);
    r.live_blocks = CNT_W'(blocks_q);
    return r;
  endfunction

  // Send one request beat after a gap; hold start until the block takes it.
  task automatic send_request(cpa_in_t it, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = it;
    do @(posedge clk_i); while (busy);
    pending_rsp.push_back(pool_outcome(it));
  endtask

  task automatic send_random_gap(cpa_in_t it);
    // Leave long runs of back-to-back beats as well as scattered gaps.
    send_request(it, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
  endtask

  task automatic drop_start();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Wait until every expected result is back, then let the block settle.
  task automatic drain();
    drop_start();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_chunk_bytes(logic [31:0] value);
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = REG_CHUNK_BYTES;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    chunk_size_q = value[CFG_W-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic cpa_in_t make_alloc(int unsigned bytes);
    cpa_in_t it;
    it.mode = MODE_ALLOC;
    it.request_bytes = bytes[REQ_W-1:0];
    it.block_index = HEAD_W'($urandom());
    return it;
  endfunction

  function automatic cpa_in_t make_free(int unsigned idx);
    cpa_in_t it;
    it.mode = MODE_FREE;
    it.request_bytes = REQ_W'($urandom());
    it.block_index = idx[HEAD_W-1:0];
    return it;
  endfunction

  // Zero size, oversize, rounding edges and frees of heads and non-heads at reset size.
  task automatic test_basic_requests();
    send_request(make_alloc(0), 0);
    send_request(make_alloc(1), 0);
    send_request(make_alloc(128), 3);
    send_request(make_alloc(129), 0);
    send_request(make_alloc(24'hFFFFFF), 1);
    send_request(make_free(255), 0);
    send_request(make_free(2), 0);
    send_request(make_free(1), 2);
    send_request(make_free(1), 0);
    send_request(make_free(0), 0);
    send_request(make_free(3), 0);
    drain();
  endtask

  // Grab the whole pool, then release it; then allocate and free a maximal request at the largest chunk size.
  task automatic test_full_pool();
    write_chunk_bytes(65536);
    send_request(make_alloc(24'hFFFFFF), 0);
    send_request(make_alloc(1), 0);
    send_request(make_free(0), 0);
    send_request(make_free(0), 0);
    write_chunk_bytes(131071);
    send_request(make_alloc(24'hFFFFFF), 0);
    send_request(make_free(0), 0);
    drain();
  endtask

  // Runs must stop at the last chunk; the search wraps back to chunk 0.
  task automatic test_end_of_pool();
    write_chunk_bytes(0);
    send_request(make_alloc(250), 0);
    send_request(make_alloc(10), 0);
    send_request(make_alloc(6), 0);
    send_request(make_free(0), 4);
    send_request(make_alloc(3), 0);
    send_request(make_free(0), 0);
    send_request(make_free(250), 0);
    drain();
  endtask

  // Mostly well-formed traffic: allocations of small runs and frees of live
  // heads, with a share of noise beats carrying random fields.
  task automatic test_random_traffic(int unsigned count);
    int unsigned heads[$];
    int unsigned cb;
    int unsigned need;
    int unsigned roll;
    longint      bytes;
    cb = (chunk_size_q == 0) ? 1 : chunk_size_q;
    for (int n = 0; n < count; n++) begin
      heads.delete();
      foreach (run_len[i]) if (run_len[i] != 0) heads.push_back(i);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        need = ($urandom_range(0, 9) == 0) ? $urandom_range(1, POOL)
                                            : $urandom_range(1, 8);
        bytes = longint'(need - 1) * cb + $urandom_range(1, cb);
        if (bytes > 24'hFFFFFF) bytes = 24'hFFFFFF;
        send_random_gap(make_alloc(32'(bytes)));
      end else if (roll < 85 && heads.size() != 0) begin
        send_random_gap(make_free(heads[$urandom_range(0, heads.size() - 1)]));
      end else begin
        send_random_gap(cpa_in_t'({1'($urandom()), 32'($urandom())}));
      end
    end
    drain();
  endtask

  task automatic test_random_phases();
    int unsigned sizes[7] = '{1, 7, 0, 128, 4096, 65536, 131071};
    foreach (sizes[i]) begin
      write_chunk_bytes(sizes[i]);
      test_random_traffic(265);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Take every result beat on done_o and compare it with the oldest prediction.
  always @(posedge clk_i) begin
    cpa_out_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, rsp_o);
        fail_count++;
      end else begin
        exp_r = pending_rsp.pop_front();
        check_field("status", exp_r.status, rsp_o.status);
        check_field("head_index", exp_r.head_index, rsp_o.head_index);
        check_field("granted_bytes", exp_r.granted_bytes, rsp_o.granted_bytes);
        check_field("used_chunks", exp_r.used_chunks, rsp_o.used_chunks);
        check_field("live_blocks", exp_r.live_blocks, rsp_o.live_blocks);
      end
    end
  end

  initial begin
    foreach (run_len[i]) run_len[i] = 0;
    cursor_q = 0;
    used_q = 0;
    blocks_q = 0;
    chunk_size_q = CHUNK_BYTES_RST;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_requests();
    test_full_pool();
    test_end_of_pool();
    test_random_phases();
    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #500000000;
    $display("status: fail");
    $finish;
  end

endmodule
